@@ rtl/multi_queue_ping_pong_buffer_top_defines.svh @@
// Assertion macros shared by the checker of the ping-pong queue buffer.
// Depends on nothing; include by bare file name.
`ifndef MULTI_QUEUE_PING_PONG_BUFFER_TOP_DEFINES_SVH
`define MULTI_QUEUE_PING_PONG_BUFFER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MQPPB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mqppb assertion failed");

// Next-cycle implication, disabled during reset.
`define MQPPB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mqppb assertion failed");

`endif

@@ rtl/mqppb_pkg.sv @@
// Shared constants of the ping-pong queue buffer: default sizes and codes.
// No dependencies.
package mqppb_pkg;

  localparam int DEF_NUM_QUEUES   = 16;
  localparam int DEF_BANK_DEPTH   = 256;
  localparam int DEF_HANDLE_WIDTH = 32;

  // Operation kinds carried by a command beat.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_GET    = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

@@ rtl/mqppb_cmd_if.sv @@
// Command channel of the ping-pong queue buffer: valid/ready plus payload.
// No dependencies.
interface mqppb_cmd_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  queue_id;
  logic [31:0] message_handle;

  modport source (output valid, kind, queue_id, message_handle, input ready);
  modport sink (input valid, kind, queue_id, message_handle, output ready);
endinterface

@@ rtl/mqppb_rsp_if.sv @@
// Result channel of the ping-pong queue buffer: valid/ready plus payload.
// No dependencies.
interface mqppb_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        got_message;
  logic [31:0] out_handle;

  modport source (output valid, status, got_message, out_handle, input ready);
  modport sink (input valid, status, got_message, out_handle, output ready);
endinterface

@@ rtl/mqppb_bank_store.sv @@
// Handle store: one write port, one read port, registered read data.
// No dependencies; contents are undefined until written.
module mqppb_bank_store #(
  parameter int ADDR_W = 13,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/multi_queue_ping_pong_buffer_top.sv @@
// Ping-pong queue buffer. One command at a time: an insert passes through the
// lookup and emit states, a get that returns a handle through lookup, fetch and
// emit (queue record read, then handle store read). The emit state waits for a free
// output register; the result sits there, so a new command is taken while it waits.
// Synchronous reset starts a clearing pass over every queue record; commands are
// held off until it ends.
module multi_queue_ping_pong_buffer_top
  import mqppb_pkg::*;
#(
  parameter int NUM_QUEUES   = DEF_NUM_QUEUES,
  parameter int BANK_DEPTH   = DEF_BANK_DEPTH,
  parameter int HANDLE_WIDTH = DEF_HANDLE_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  mqppb_cmd_if.sink  cmd,
  mqppb_rsp_if.source rsp
);

  localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int AW  = $clog2(BANK_DEPTH);
  localparam int CW  = $clog2(BANK_DEPTH + 1);
  localparam int SAW = QW + 1 + AW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  // Per-queue record: write bank select, read position and both fill counts.
  typedef struct packed {
    logic          wsel;
    logic [CW-1:0] rpos;
    logic [CW-1:0] fill1;
    logic [CW-1:0] fill0;
  } qrec_t;

  logic [2:0]              state;
  logic [2:0]              state_next;
  logic [QW-1:0]           clr_addr;
  logic                    op_kind;
  logic [QW-1:0]           op_qidx;
  logic                    op_inrange;
  logic [HANDLE_WIDTH-1:0] op_handle;
  logic [1:0]              res_status;
  logic                    res_got;
  logic                    out_valid;
  logic [1:0]              out_status;
  logic                    out_got;
  logic [31:0]             out_handle;

  qrec_t                   rec_mem [NUM_QUEUES];
  qrec_t                   rec_rdata;
  qrec_t                   rec_wdata;
  logic                    rec_we;
  logic [QW-1:0]           rec_waddr;

  logic                    cmd_fire;
  logic [15:0]             qid_wide;
  logic [63:0]             hnd_wide;
  logic [63:0]             rd_wide;
  logic                    out_free;

  logic                    store_we;
  logic [SAW-1:0]          store_waddr;
  logic                    store_re;
  logic [SAW-1:0]          store_raddr;
  logic [HANDLE_WIDTH-1:0] store_rdata;

  // Lookup results of the current command.
  logic                    rb;
  logic [CW-1:0]           fill_rb;
  logic                    swap;
  logic                    rb2;
  logic [CW-1:0]           rpos2;
  logic [CW-1:0]           fill_rb2;
  logic                    hit;
  logic [CW-1:0]           fill_wb;
  logic                    full;
  qrec_t                   rec_upd;

  assign cmd_fire  = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign qid_wide  = 16'(cmd.queue_id);
  assign hnd_wide  = 64'(cmd.message_handle);
  assign rd_wide   = 64'(store_rdata);
  assign out_free  = !out_valid || rsp.ready;

  // Decode the queue record for insert and get.
  always_comb begin
    rb       = ~rec_rdata.wsel;
    fill_rb  = rb ? rec_rdata.fill1 : rec_rdata.fill0;
    swap     = (rec_rdata.rpos >= fill_rb);
    rb2      = swap ? rec_rdata.wsel : rb;
    rpos2    = swap ? '0 : rec_rdata.rpos;
    fill_rb2 = rb2 ? rec_rdata.fill1 : rec_rdata.fill0;
    hit      = (rpos2 < fill_rb2) && (rpos2 < CW'(BANK_DEPTH));
    fill_wb  = rec_rdata.wsel ? rec_rdata.fill1 : rec_rdata.fill0;
    full     = (fill_wb >= CW'(BANK_DEPTH));
    rec_upd  = rec_rdata;
    if (op_kind == KIND_INSERT) begin
      if (!full) begin
        if (rec_rdata.wsel) begin
          rec_upd.fill1 = fill_wb + CW'(1);
        end else begin
          rec_upd.fill0 = fill_wb + CW'(1);
        end
      end
    end else begin
      if (swap) begin
        rec_upd.wsel = rb;
        if (rb) begin
          rec_upd.fill1 = '0;
        end else begin
          rec_upd.fill0 = '0;
        end
      end
      rec_upd.rpos = hit ? (rpos2 + CW'(1)) : rpos2;
    end
  end

  // Record memory write: zeros during the clearing pass, updates on lookup.
  always_comb begin
    rec_we    = 1'b0;
    rec_waddr = op_qidx;
    rec_wdata = rec_upd;
    if (state == S_CLEAR) begin
      rec_we    = 1'b1;
      rec_waddr = clr_addr;
      rec_wdata = '0;
    end else if (state == S_LOOK) begin
      rec_we = op_inrange;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      rec_rdata <= rec_mem[qid_wide[QW-1:0]];
    end
  end

  // Handle store accesses, both issued in the lookup cycle.
  assign store_we    = (state == S_LOOK) && op_inrange && (op_kind == KIND_INSERT) && !full;
  assign store_waddr = {op_qidx, rec_rdata.wsel, fill_wb[AW-1:0]};
  assign store_re    = (state == S_LOOK) && op_inrange && (op_kind == KIND_GET) && hit;
  assign store_raddr = {op_qidx, rb2, rpos2[AW-1:0]};

  mqppb_bank_store #(
    .ADDR_W (SAW),
    .DATA_W (HANDLE_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (op_handle),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == QW'(NUM_QUEUES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_fire) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = store_re ? S_FETCH : S_EMIT;
      end
      S_FETCH: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + QW'(1);
      end
    end
  end

  // Command capture.
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      op_kind    <= cmd.kind;
      op_qidx    <= qid_wide[QW-1:0];
      op_inrange <= ({28'b0, cmd.queue_id} < NUM_QUEUES);
      op_handle  <= hnd_wide[HANDLE_WIDTH-1:0];
    end
  end

  // Result code, settled in the lookup cycle.
  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      res_got <= store_re;
      if (op_kind == KIND_INSERT) begin
        res_status <= (!op_inrange || full) ? ST_FULL : ST_OK;
      end else begin
        res_status <= (!op_inrange || !hit) ? ST_EMPTY : ST_OK;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      out_status <= res_status;
      out_got    <= res_got;
      out_handle <= res_got ? rd_wide[31:0] : 32'd0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.got_message = out_got;
  assign rsp.out_handle  = out_handle;

endmodule

@@ rtl/mqppb_checker.sv @@
// Port-level checks of the ping-pong queue buffer, bound to the top level.
// Depends on mqppb_pkg and the assertion macro header.
`include "multi_queue_ping_pong_buffer_top_defines.svh"

module mqppb_checker
  import mqppb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic        rsp_got,
  input logic [31:0] rsp_handle
);

  // A returned handle always comes with an ok status.
  `MQPPB_ASSERT_IMP(a_got_ok, clk, rst, rsp_valid && rsp_got, rsp_status == ST_OK)

  // A beat that carries no handle shows a zero handle.
  `MQPPB_ASSERT_IMP(a_nogot_zero, clk, rst, rsp_valid && !rsp_got, rsp_handle == 32'd0)

  // Commands are worked one at a time: no accept right after an accept.
  `MQPPB_ASSERT_NXT(a_one_at_a_time, clk, rst, cmd_valid && cmd_ready, !cmd_ready)

  // A stalled result beat stays valid.
  `MQPPB_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind multi_queue_ping_pong_buffer_top mqppb_checker u_mqppb_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_got    (rsp.got_message),
  .rsp_handle (rsp.out_handle)
);

@@ tb/sv/tb_multi_queue_ping_pong_buffer_top.sv @@
// Self-checking testbench for the multi-queue ping-pong message buffer.
// Depends on mqppb_pkg, the mqppb_cmd_if and mqppb_rsp_if interfaces and the top.
module tb_multi_queue_ping_pong_buffer_top;
  import mqppb_pkg::*;

  localparam int NQ          = DEF_NUM_QUEUES;
  localparam int DEPTH       = DEF_BANK_DEPTH;
  localparam int RANDOM_OPS  = 1200;
  localparam int STALL_LIMIT = 500;
  localparam int DRAIN_WAIT  = 10;
  localparam int PLAN_LEN    = 21;

  typedef struct packed {
    logic [1:0]  status;
    logic        got;
    logic [31:0] handle;
  } outcome_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  queue_id;
    logic [31:0] handle;
    int          reps;
    bit          typed;
    outcome_t    want;
  } stim_row_t;

  localparam outcome_t RES_OK    = '{status: ST_OK,    got: 1'b0, handle: 32'd0};
  localparam outcome_t RES_FULL  = '{status: ST_FULL,  got: 1'b0, handle: 32'd0};
  localparam outcome_t RES_EMPTY = '{status: ST_EMPTY, got: 1'b0, handle: 32'd0};

  logic clk = 1'b0;
  logic rst = 1'b1;

  mqppb_cmd_if cmd ();
  mqppb_rsp_if rsp ();

  multi_queue_ping_pong_buffer_top uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  // Shadow copy of the queue state, kept in step with accepted commands.
  logic [31:0] handle_mem [NQ][2][DEPTH];
  logic [8:0]  bank_count [NQ][2];
  logic [8:0]  read_idx   [NQ];
  logic        wr_bank    [NQ];

  outcome_t pending_outcomes [$];
  bit       failed = 1'b0;
  bit       quiet  = 1'b0;
  int       idle_cycles = 0;

  // Directed plan: edge values, both operations, swap, full bank and empty queue.
  stim_row_t plan [PLAN_LEN] = '{
    '{KIND_GET,    4'd0,  32'h0000_0000, 1,   1'b1, RES_EMPTY},
    '{KIND_GET,    4'd15, 32'hFFFF_FFFF, 1,   1'b1, RES_EMPTY},
    '{KIND_INSERT, 4'd0,  32'h0000_0000, 1,   1'b1, RES_OK},
    '{KIND_INSERT, 4'd15, 32'hFFFF_FFFF, 1,   1'b1, RES_OK},
    '{KIND_INSERT, 4'd0,  32'hA5A5_5A5A, 1,   1'b1, RES_OK},
    '{KIND_GET,    4'd0,  32'h0000_0000, 1,   1'b1,
      '{status: ST_OK, got: 1'b1, handle: 32'h0000_0000}},
    '{KIND_GET,    4'd15, 32'h0000_0000, 1,   1'b1,
      '{status: ST_OK, got: 1'b1, handle: 32'hFFFF_FFFF}},
    '{KIND_INSERT, 4'd0,  32'h1234_5678, 1,   1'b0, RES_OK},
    '{KIND_GET,    4'd0,  32'h0000_0000, 1,   1'b0, RES_OK},
    '{KIND_GET,    4'd0,  32'h0000_0000, 1,   1'b0, RES_OK},
    '{KIND_GET,    4'd0,  32'h0000_0000, 1,   1'b0, RES_OK},
    '{KIND_GET,    4'd15, 32'h0000_0000, 1,   1'b0, RES_OK},
    '{KIND_INSERT, 4'd9,  32'h9000_0000, 256, 1'b0, RES_OK},
    '{KIND_INSERT, 4'd9,  32'hDEAD_BEEF, 1,   1'b1, RES_FULL},
    '{KIND_GET,    4'd9,  32'h0000_0000, 1,   1'b0, RES_OK},
    '{KIND_INSERT, 4'd9,  32'h6000_0000, 3,   1'b0, RES_OK},
    '{KIND_GET,    4'd9,  32'h0000_0000, 255, 1'b0, RES_OK},
    '{KIND_GET,    4'd9,  32'h0000_0000, 4,   1'b0, RES_OK},
    '{KIND_INSERT, 4'd3,  32'h0000_0001, 1,   1'b0, RES_OK},
    '{KIND_INSERT, 4'd3,  32'h8000_0000, 1,   1'b0, RES_OK},
    '{KIND_GET,    4'd3,  32'h0000_0000, 3,   1'b0, RES_OK}
  };

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one command to the shadow state and return what the block should answer.
  function automatic outcome_t apply_queue_op(logic k, logic [3:0] q, logic [31:0] h);
    outcome_t res;
    logic     rb;
    res = RES_OK;
    if (k == KIND_INSERT) begin
      if (bank_count[q][wr_bank[q]] >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        handle_mem[q][wr_bank[q]][bank_count[q][wr_bank[q]][7:0]] = h;
        bank_count[q][wr_bank[q]] = bank_count[q][wr_bank[q]] + 9'd1;
      end
    end else begin
      rb = ~wr_bank[q];
      // A drained read bank swaps roles with the write bank, which is then emptied.
      if (read_idx[q] >= bank_count[q][rb]) begin
        wr_bank[q] = rb;
        bank_count[q][rb] = 9'd0;
        rb = ~rb;
        read_idx[q] = 9'd0;
      end
      if (read_idx[q] >= bank_count[q][rb]) begin
        res.status = ST_EMPTY;
      end else begin
        res.got = 1'b1;
        res.handle = handle_mem[q][rb][read_idx[q][7:0]];
        read_idx[q] = read_idx[q] + 9'd1;
      end
    end
    return res;
  endfunction

  // Handles lean toward the all-zero and all-one patterns now and then.
  function automatic logic [31:0] pick_handle();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Offer one command beat after a random gap and record its outcome once taken.
  task automatic send_cmd(input logic k, input logic [3:0] q, input logic [31:0] h,
                          input bit typed, input outcome_t want);
    int       gap;
    outcome_t calc;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid          <= 1'b1;
    cmd.kind           <= k;
    cmd.queue_id       <= q;
    cmd.message_handle <= h;
    do @(posedge clk); while (cmd.ready !== 1'b1);
    calc = apply_queue_op(k, q, h);
    pending_outcomes.push_back(typed ? want : calc);
  endtask

  // Reset and all inputs start at known values.
  initial begin
    cmd.valid          <= 1'b0;
    cmd.kind           <= KIND_INSERT;
    cmd.queue_id       <= 4'd0;
    cmd.message_handle <= 32'd0;
    rsp.ready          <= 1'b0;
    for (int q = 0; q < NQ; q++) begin
      bank_count[q][0] = 9'd0;
      bank_count[q][1] = 9'd0;
      read_idx[q]      = 9'd0;
      wr_bank[q]       = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Main stimulus: directed plan, then random traffic, then drain and verdict.
  initial begin : stimulus
    int sent;
    int sel;
    int hot;
    int n;
    logic [3:0] q;
    logic       k;
    sent = 0;
    wait (rst === 1'b0);

    foreach (plan[r]) begin
      for (int i = 0; i < plan[r].reps; i++) begin
        send_cmd(plan[r].kind, plan[r].queue_id, plan[r].handle + i,
                 plan[r].typed, plan[r].want);
      end
    end

    while (sent < RANDOM_OPS) begin
      quiet = ($urandom_range(0, 5) == 0);
      sel = $urandom_range(0, 49);
      if (sel == 0) begin
        // Fill one queue to near or past its bank depth, then read it back out.
        q = 4'($urandom_range(0, NQ - 1));
        n = $urandom_range(250, 262);
        repeat (n) send_cmd(KIND_INSERT, q, pick_handle(), 1'b0, RES_OK);
        sent += n;
        n = $urandom_range(250, 270);
        repeat (n) send_cmd(KIND_GET, q, pick_handle(), 1'b0, RES_OK);
        sent += n;
      end else begin
        // A short burst centered on one hot queue with a few strays.
        hot = $urandom_range(0, NQ - 1);
        n = $urandom_range(1, 24);
        for (int i = 0; i < n; i++) begin
          q = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, NQ - 1)) : 4'(hot);
          k = ($urandom_range(0, 99) < 55) ? KIND_INSERT : KIND_GET;
          send_cmd(k, q, pick_handle(), 1'b0, RES_OK);
        end
        sent += n;
      end
    end
    cmd.valid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: random stalls, every beat compared with the oldest outcome.
  initial begin : result_check
    int       stall;
    outcome_t want;
    wait (rst === 1'b0);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!(rsp.valid === 1'b1 && rsp.ready === 1'b1));
      if (pending_outcomes.size() == 0) begin
        $error("result beat with no outstanding command");
        failed = 1'b1;
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp.status !== want.status) begin
          $error("field status expected %0d actual %0d", want.status, rsp.status);
          failed = 1'b1;
        end
        if (rsp.got_message !== want.got) begin
          $error("field got_message expected %0d actual %0d", want.got, rsp.got_message);
          failed = 1'b1;
        end
        if (rsp.out_handle !== want.handle) begin
          $error("field out_handle expected %h actual %h", want.handle, rsp.out_handle);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: too many cycles without any beat on either channel ends the run.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((cmd.valid === 1'b1 && cmd.ready === 1'b1) ||
                 (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/mqppb_pkg.sv
rtl/mqppb_cmd_if.sv
rtl/mqppb_rsp_if.sv
rtl/mqppb_bank_store.sv
rtl/multi_queue_ping_pong_buffer_top.sv
rtl/mqppb_checker.sv
tb/sv/tb_multi_queue_ping_pong_buffer_top.sv
